@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Command, status and state codes shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_PAST  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    EDIT_HOLD = 2'd0,
    EDIT_INS  = 2'd1,
    EDIT_DEL  = 2'd2,
    EDIT_ROT  = 2'd3
  } edit_t;

  // Controller to datapath.
  typedef struct packed {
    logic op_start;  // command transaction accepted this cycle
    logic rd_step;   // current result taken, load the next read-out element
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_last;  // result in the output register is the final one
  } dp_stat_t;

  localparam int unsigned CountW = 7;

endpackage

@@ hw/rtl/ple_req_if.sv @@
// ----------------------------------------------------------------------------
// ple_req_if
// Command channel: valid/ready with command, value and position.
// ----------------------------------------------------------------------------
interface ple_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [7:0]         position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

@@ hw/rtl/ple_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ple_rsp_if
// Result channel: valid/ready with element value, status, count and last.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_value;
  logic [1:0]         status;
  logic [6:0]         count;
  logic               last;

  modport source (output valid, output elem_value, output status, output count,
                  output last, input ready);
  modport sink   (input valid, input elem_value, input status, input count,
                  input last, output ready);
endinterface

@@ hw/rtl/positional_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with insert/delete at front, end or
// position and a front-to-back read out.
// ----------------------------------------------------------------------------
//
//   channel | dir | fields                              | transaction
//   --------+-----+-------------------------------------+---------------------
//   req     | in  | cmd, value, position                | one command
//   rsp     | out | elem_value, status, count, last     | one result
//
// Sequencing: when a command is taken its result appears the next cycle;
//   the next command is taken the cycle after the final result is taken, so
//   the engine never takes a new command while a result is still pending.
// Read out produces one element per cycle while rsp is ready; the rate is
//   set by the single result register and the two-state controller.
// Reset: rst clears the length and the controller; stored values are not
//   cleared and need no sweep, since only entries below the length are read.
// Stalls: a stalled result holds in the result register; req stays not ready.
//
module positional_list_engine_core #(
  parameter int unsigned DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Controller: sequence accept and result drain.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  // Datapath: storage, shift network and result register.
  ple_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cmd        (req.cmd),
    .value      (req.value),
    .position   (req.position),
    .elem_value (rsp.elem_value),
    .status     (rsp.status),
    .count      (rsp.count),
    .last       (rsp.last)
  );

endmodule

@@ hw/rtl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Two-state controller: take a command, then drain its results.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ple_pkg::ctl_cmd_t ctl,
  input  ple_pkg::dp_stat_t stat
);
  import ple_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (rsp_ready && stat.out_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    rsp_valid    = 1'b0;
    ctl.op_start = 1'b0;
    ctl.rd_step  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        ctl.op_start = req_valid;
      end
      S_EMIT: begin
        rsp_valid   = 1'b1;
        ctl.rd_step = rsp_ready && !stat.out_last;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/ple_dp.sv @@
// ----------------------------------------------------------------------------
// ple_dp
// List storage with a shift network for insert/delete/rotate and a result register.
// ----------------------------------------------------------------------------
module ple_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::ctl_cmd_t  ctl,
  output ple_pkg::dp_stat_t  stat,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  output logic signed [31:0] elem_value,
  output logic [1:0]         status,
  output logic [6:0]         count,
  output logic               last
);
  import ple_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic signed [31:0] ent      [DEPTH];
  logic signed [31:0] ent_next [DEPTH];
  logic [LW-1:0]      len;
  logic [LW-1:0]      len_next;
  logic [LW-1:0]      rd_left;
  logic [LW-1:0]      rd_left_next;

  edit_t              edit;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      rot_end;
  logic [7:0]         pos_eff;
  logic [7:0]         pos_m1;
  logic [7:0]         len8;
  logic               full;
  logic               empty;

  logic               out_load;
  logic signed [31:0] o_elem;
  status_t            o_status;
  logic               o_last;

  assign pos_eff = (position == 8'd0) ? 8'd1 : position;
  assign pos_m1  = pos_eff - 8'd1;
  assign len8    = 8'(len);
  assign full    = (len == LW'(DEPTH));
  assign empty   = (len == '0);
  assign rot_end = IW'(len - LW'(1));

  // Command decode and result formation.
  always_comb begin
    edit         = EDIT_HOLD;
    idx          = '0;
    len_next     = len;
    rd_left_next = rd_left;
    out_load     = 1'b0;
    o_elem       = '0;
    o_status     = ST_OK;
    o_last       = 1'b1;
    if (ctl.op_start) begin
      out_load = 1'b1;
      case (cmd_t'(cmd))
        CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
          if (full) begin
            o_status = ST_FULL;
          end else begin
            edit     = EDIT_INS;
            len_next = len + LW'(1);
            if (cmd_t'(cmd) == CMD_INS_FRONT) begin
              idx = '0;
            end else if (cmd_t'(cmd) == CMD_INS_END || pos_m1 >= len8) begin
              idx = IW'(len);
            end else begin
              idx = IW'(pos_m1);
            end
          end
        end
        CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
          if (empty) begin
            o_status = ST_EMPTY;
          end else if (cmd_t'(cmd) == CMD_DEL_AT && pos_eff > len8) begin
            o_status = ST_PAST;
          end else begin
            edit     = EDIT_DEL;
            len_next = len - LW'(1);
            if (cmd_t'(cmd) == CMD_DEL_FRONT) begin
              idx = '0;
            end else if (cmd_t'(cmd) == CMD_DEL_END) begin
              idx = rot_end;
            end else begin
              idx = IW'(pos_m1);
            end
          end
        end
        CMD_READ: begin
          if (empty) begin
            o_status = ST_EMPTY;
          end else begin
            edit         = EDIT_ROT;
            o_elem       = ent[0];
            o_last       = (len == LW'(1));
            rd_left_next = len - LW'(1);
          end
        end
        default: begin
          o_status = ST_OK;
        end
      endcase
    end else if (ctl.rd_step) begin
      edit         = EDIT_ROT;
      out_load     = 1'b1;
      o_elem       = ent[0];
      o_last       = (rd_left == LW'(1));
      rd_left_next = rd_left - LW'(1);
    end
  end

  // Per-entry next value: shift up, shift down or rotate toward the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    logic signed [31:0] below;
    logic signed [31:0] above;
    if (i == 0) begin : g_lo
      assign below = ent[i];
    end else begin : g_mid_lo
      assign below = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above = ent[i];
    end else begin : g_mid_hi
      assign above = ent[i+1];
    end

    always_comb begin
      ent_next[i] = ent[i];
      case (edit)
        EDIT_INS: begin
          if (IW'(i) == idx)      ent_next[i] = value;
          else if (IW'(i) > idx)  ent_next[i] = below;
        end
        EDIT_DEL: begin
          if (IW'(i) >= idx) ent_next[i] = above;
        end
        EDIT_ROT: begin
          ent_next[i] = (IW'(i) == rot_end) ? ent[0] : above;
        end
        default: ent_next[i] = ent[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      ent[j] <= ent_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_left <= rd_left_next;
    if (out_load) begin
      elem_value <= o_elem;
      status     <= o_status;
      count      <= CountW'(len_next);
      last       <= o_last;
    end
  end

  assign stat.out_last = last;

endmodule

@@ hw/rtl/ple_chk.sv @@
// ----------------------------------------------------------------------------
// ple_chk
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_chk #(
  parameter int unsigned DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [6:0] rsp_count,
  input logic       rsp_last
);
  import ple_pkg::*;

  // No new command while any result of the previous one is pending.
  `ASSERT_IMPL(a_no_overlap, rsp_valid, !(req_valid && req_ready), "command during result")

  // Length never exceeds the store size.
  `ASSERT_IMPL(a_count_max, rsp_valid, rsp_count <= 7'(DEPTH), "count exceeds depth")

  // A refused insert only happens on a full list.
  `ASSERT_IMPL(a_full_cnt, rsp_valid && rsp_status == ST_FULL, rsp_count == 7'(DEPTH), "early full")

  // After the final result is taken the output goes idle.
  `ASSERT_NEXT(a_last_done, rsp_valid && rsp_ready && rsp_last, !rsp_valid, "result after last")

  // A stalled result holds.
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count), "result lost")

endmodule

bind positional_list_engine_core ple_chk #(
  .DEPTH (DEPTH)
) u_ple_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.count),
  .rsp_last   (rsp.last)
);
